/* rtl/core/pis_pkg.sv */
// ----------------------------------------------------------------------------
// pis_pkg
// shared constants for the integral-separation pid controller: register
// map, field widths and reset values of the configuration registers
// ----------------------------------------------------------------------------
package pis_pkg;

    // payload and register widths
    localparam int SampleW = 16;
    localparam int GainW   = 16;
    localparam int LimitW  = 15;
    localparam int DataW   = 32;
    localparam int AddrW   = 5;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] RegPropGain  = 3'd0;
    localparam logic [2:0] RegIntegGain = 3'd1;
    localparam logic [2:0] RegDerivGain = 3'd2;
    localparam logic [2:0] RegSumLimit  = 3'd3;
    localparam logic [2:0] RegDriveLim  = 3'd4;
    localparam logic [2:0] RegSepThresh = 3'd5;

    // reset values
    localparam logic [GainW-1:0]  PropGainRst  = 16'd4915;
    localparam logic [GainW-1:0]  IntegGainRst = 16'd164;
    localparam logic [GainW-1:0]  DerivGainRst = 16'd410;
    localparam logic [LimitW-1:0] SumLimitRst  = 15'd7680;
    localparam logic [LimitW-1:0] DriveLimRst  = 15'd2560;
    localparam logic [LimitW-1:0] SepThreshRst = 15'd2560;

    // rounding constant for q.20 to q8.8 (half of 4096)
    localparam logic signed [35:0] RoundHalf = 36'sd2048;

endpackage

/* rtl/core/pid_integral_separation.sv */
// ----------------------------------------------------------------------------
// pid_integral_separation
// pid controller with integral separation and a clamped error sum
// ----------------------------------------------------------------------------
// usage
//   error channel (err_valid / err_ready / error): one signed q8.8 error
//   sample per transfer. drive channel (drive_valid / drive_ready / drive):
//   one saturated q8.8 drive value per error sample, in order.
//   apb port: six registers at byte addresses 0, 4, .. 20 (gains, sum
//   limit, drive limit, separation threshold). write only while idle.
// pipeline and throughput
//   three register stages (state update, gain multiply, sum / round /
//   saturate) lie between the error transfer and drive_valid. one sample
//   per cycle sustained while drive_ready stays high; the three gain
//   multipliers of the product stage set the cycle time.
// reset
//   rst_n clears the pipeline valid bits, the error sum and the previous
//   error, and loads the default gains and limits.
// stall
//   when drive_valid is high and drive_ready low the whole pipeline holds
//   and err_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pid_integral_separation
(
    input  logic                                clk,
    input  logic                                rst_n,
    // error sample channel
    input  logic                                err_valid,
    output logic                                err_ready,
    input  logic signed [pis_pkg::SampleW-1:0]  error,
    // drive channel
    output logic                                drive_valid,
    input  logic                                drive_ready,
    output logic signed [pis_pkg::SampleW-1:0]  drive,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pis_pkg::AddrW-1:0]           paddr,
    input  logic [pis_pkg::DataW-1:0]           pwdata,
    output logic [pis_pkg::DataW-1:0]           prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [pis_pkg::GainW-1:0]  prop_gain_reg;
    logic [pis_pkg::GainW-1:0]  integ_gain_reg;
    logic [pis_pkg::GainW-1:0]  deriv_gain_reg;
    logic [pis_pkg::LimitW-1:0] sum_limit_reg;
    logic [pis_pkg::LimitW-1:0] drive_limit_reg;
    logic [pis_pkg::LimitW-1:0] sep_thresh_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= pis_pkg::PropGainRst;
            integ_gain_reg  <= pis_pkg::IntegGainRst;
            deriv_gain_reg  <= pis_pkg::DerivGainRst;
            sum_limit_reg   <= pis_pkg::SumLimitRst;
            drive_limit_reg <= pis_pkg::DriveLimRst;
            sep_thresh_reg  <= pis_pkg::SepThreshRst;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pis_pkg::RegPropGain:  prop_gain_reg   <= pwdata[15:0];
                pis_pkg::RegIntegGain: integ_gain_reg  <= pwdata[15:0];
                pis_pkg::RegDerivGain: deriv_gain_reg  <= pwdata[15:0];
                pis_pkg::RegSumLimit:  sum_limit_reg   <= pwdata[14:0];
                pis_pkg::RegDriveLim:  drive_limit_reg <= pwdata[14:0];
                pis_pkg::RegSepThresh: sep_thresh_reg  <= pwdata[14:0];
                default:               ; // unmapped, write dropped
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        case (cfg_index)
            pis_pkg::RegPropGain:  prdata = {16'd0, prop_gain_reg};
            pis_pkg::RegIntegGain: prdata = {16'd0, integ_gain_reg};
            pis_pkg::RegDerivGain: prdata = {16'd0, deriv_gain_reg};
            pis_pkg::RegSumLimit:  prdata = {17'd0, sum_limit_reg};
            pis_pkg::RegDriveLim:  prdata = {17'd0, drive_limit_reg};
            pis_pkg::RegSepThresh: prdata = {17'd0, sep_thresh_reg};
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together unless the output
    // register holds a result the receiver has not taken
    // ------------------------------------------------------------------
    logic advance;
    logic err_xfer;

    assign advance   = !drive_valid || drive_ready;
    assign err_ready = advance;
    assign err_xfer  = err_valid && err_ready;

    // ------------------------------------------------------------------
    // stage a: separation test, error sum update, error difference
    // ------------------------------------------------------------------
    logic signed [15:0] error_sum_reg;
    logic signed [15:0] error_sum_next;
    logic signed [15:0] last_error_reg;

    logic signed [16:0] err_ext;
    logic        [16:0] err_mag;
    logic               integrate;
    logic signed [16:0] sum_raw;
    logic signed [16:0] sum_lim_pos;
    logic signed [16:0] sum_lim_neg;

    always_comb
    begin
        err_ext     = {error[15], error};
        err_mag     = error[15] ? 17'(-err_ext) : 17'(err_ext);
        integrate   = err_mag < {2'd0, sep_thresh_reg};
        sum_raw     = {error_sum_reg[15], error_sum_reg} + err_ext;
        sum_lim_pos = $signed({2'd0, sum_limit_reg});
        sum_lim_neg = -sum_lim_pos;
        if (!integrate)
        begin
            error_sum_next = '0;
        end
        else if (sum_raw > sum_lim_pos)
        begin
            error_sum_next = sum_lim_pos[15:0];
        end
        else if (sum_raw < sum_lim_neg)
        begin
            error_sum_next = sum_lim_neg[15:0];
        end
        else
        begin
            error_sum_next = sum_raw[15:0];
        end
    end

    logic               a_valid_reg;
    logic signed [15:0] a_err_reg;
    logic signed [15:0] a_sum_reg;
    logic signed [16:0] a_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            a_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= err_valid;
            if (err_xfer)
            begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= error;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (err_xfer)
        begin
            a_err_reg   <= error;
            a_sum_reg   <= error_sum_next;
            a_delta_reg <= err_ext - {last_error_reg[15], last_error_reg};
        end
    end

    // ------------------------------------------------------------------
    // stage b: three gain products, exact q.20
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic signed [32:0] b_prop_reg;
    logic signed [32:0] b_integ_reg;
    logic signed [33:0] b_deriv_reg;

    logic signed [32:0] prop_prod;
    logic signed [32:0] integ_prod;
    logic signed [33:0] deriv_prod;

    always_comb
    begin
        prop_prod  = $signed({1'b0, prop_gain_reg}) * a_err_reg;
        integ_prod = $signed({1'b0, integ_gain_reg}) * a_sum_reg;
        deriv_prod = $signed({1'b0, deriv_gain_reg}) * a_delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            b_prop_reg  <= prop_prod;
            b_integ_reg <= integ_prod;
            b_deriv_reg <= deriv_prod;
        end
    end

    // ------------------------------------------------------------------
    // stage c: sum, round half up to q8.8, saturate to the drive limit
    // ------------------------------------------------------------------
    logic signed [35:0] acc_sum;
    logic signed [23:0] acc_q88;
    logic signed [23:0] drv_lim_pos;
    logic signed [23:0] drv_lim_neg;
    logic signed [15:0] drive_next;

    always_comb
    begin
        acc_sum = {{3{b_prop_reg[32]}}, b_prop_reg}
                + {{3{b_integ_reg[32]}}, b_integ_reg}
                + {{2{b_deriv_reg[33]}}, b_deriv_reg}
                + pis_pkg::RoundHalf;
        // arithmetic drop of twelve bits is a floor division by 4096
        acc_q88     = acc_sum[35:12];
        drv_lim_pos = $signed({9'd0, drive_limit_reg});
        drv_lim_neg = -drv_lim_pos;
        if (acc_q88 > drv_lim_pos)
        begin
            drive_next = drv_lim_pos[15:0];
        end
        else if (acc_q88 < drv_lim_neg)
        begin
            drive_next = drv_lim_neg[15:0];
        end
        else
        begin
            drive_next = acc_q88[15:0];
        end
    end

    logic               drive_valid_reg;
    logic signed [15:0] drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            drive_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an error outside the separation band clears the sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_xfer && !integrate) |=> (error_sum_reg == 16'sd0))
        else $error("error sum not cleared outside separation band");

    // previous error follows every accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        err_xfer |=> (last_error_reg == $past(error)))
        else $error("previous error not captured");

    // input only stalls behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !err_ready |-> (drive_valid && !drive_ready))
        else $error("input stalled without a waiting result");

endmodule
